>>> hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by hmil_checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/hmil_pkg.sv
// ----------------------------------------------------------------------------
// hmil_pkg
// Types and codes for the HID main item layout block.
// ----------------------------------------------------------------------------
`default_nettype none

package hmil_pkg;

  localparam logic [1:0] KIND_OTHER   = 2'd0;
  localparam logic [1:0] KIND_INPUT   = 2'd1;
  localparam logic [1:0] KIND_OUTPUT  = 2'd2;
  localparam logic [1:0] KIND_FEATURE = 2'd3;

  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_LOG_MIN  = 3'd1;
  localparam logic [2:0] ERR_LOG_MAX  = 3'd2;
  localparam logic [2:0] ERR_LOG_INV  = 3'd3;
  localparam logic [2:0] ERR_USAGE    = 3'd4;
  localparam logic [2:0] ERR_STRING   = 3'd5;
  localparam logic [2:0] ERR_DESIG    = 3'd6;
  localparam logic [2:0] ERR_PHYS_INV = 3'd7;

  localparam int CTR_INPUT   = 0;
  localparam int CTR_OUTPUT  = 1;
  localparam int CTR_FEATURE = 2;

  localparam int SIZE_CAP = 31;
  localparam int CTR_W    = 32;

  typedef struct packed {
    logic [1:0]         item_kind;
    logic [7:0]         field_size;
    logic [7:0]         field_count;
    logic [7:0]         report_number;
    logic signed [31:0] logical_low;
    logic signed [31:0] logical_high;
    logic signed [31:0] physical_low;
    logic signed [31:0] physical_high;
    logic [2:0]         half_range_marks;
    logic [15:0]        usage_total;
    logic [15:0]        string_total;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         error_code;
    logic               reversed;
    logic [1:0]         report_kind;
    logic [31:0]        start_bit;
    logic signed [31:0] fixed_logical_low;
    logic signed [31:0] fixed_logical_high;
    logic signed [31:0] fixed_physical_low;
    logic signed [31:0] fixed_physical_high;
    logic [15:0]        first_usage;
    logic [15:0]        usage_span;
    logic [15:0]        first_string;
    logic [15:0]        string_span;
  } out_item_t;

  // Classified item passed from front to back.
  typedef struct packed {
    logic [2:0]         error_code;
    logic               reversed;
    logic [1:0]         item_kind;
    logic [7:0]         rep;
    logic [15:0]        bit_add;
    logic signed [31:0] fix_log_low;
    logic signed [31:0] fix_log_high;
    logic signed [31:0] fix_phys_low;
    logic signed [31:0] fix_phys_high;
    logic [15:0]        usage_total;
    logic [15:0]        string_total;
  } cls_item_t;

  // One counter per report kind (input, output, feature) for a report.
  typedef logic [2:0][CTR_W-1:0] row_t;

endpackage

`default_nettype wire

>>> hdl/hmil_front.sv
// ----------------------------------------------------------------------------
// hmil_front
// Classifies a main item: range repair, first error, bit advance, report index.
// ----------------------------------------------------------------------------
`default_nettype none

module hmil_front #(
  parameter int NUM_REPORTS = 256
) (
  input  hmil_pkg::in_item_t  item,
  output hmil_pkg::cls_item_t cls
);
  import hmil_pkg::*;

  // ceil(2^16 / NUM_REPORTS): exact quotient for any 8-bit report number
  localparam int REP_RECIP = (65536 + NUM_REPORTS - 1) / NUM_REPORTS;

  logic [4:0]         bits;
  logic signed [31:0] top;
  logic               min_bad;
  logic               max_bad;
  logic               swap;
  logic signed [31:0] lmin1;
  logic signed [31:0] lmax1;
  logic signed [31:0] lmin2;
  logic signed [31:0] lmax2;
  logic               phys_eq_or_inv;
  logic [2:0]         err;
  logic [23:0]        rep_prod;
  logic [7:0]         rep_quo;
  logic [7:0]         rem;

  always_comb begin
    bits  = (item.field_size >= 8'(SIZE_CAP + 1)) ? 5'(SIZE_CAP) : item.field_size[4:0];
    top   = $signed((32'd1 << bits) - 32'd1);
    min_bad = item.logical_low > top;
    max_bad = item.logical_high > top;
    lmin1 = min_bad ? 32'sd0 : item.logical_low;
    lmax1 = max_bad ? top : item.logical_high;
    swap  = lmin1 > lmax1;
    lmin2 = swap ? lmax1 : lmin1;
    lmax2 = swap ? lmin1 : lmax1;
    phys_eq_or_inv = item.physical_low >= item.physical_high;

    if (min_bad) begin
      err = ERR_LOG_MIN;
    end else if (max_bad) begin
      err = ERR_LOG_MAX;
    end else if (swap) begin
      err = ERR_LOG_INV;
    end else if (item.half_range_marks[0]) begin
      err = ERR_USAGE;
    end else if (item.half_range_marks[1]) begin
      err = ERR_STRING;
    end else if (item.half_range_marks[2]) begin
      err = ERR_DESIG;
    end else if (item.physical_low > item.physical_high) begin
      err = ERR_PHYS_INV;
    end else begin
      err = ERR_NONE;
    end
  end

  // report_number modulo NUM_REPORTS by reciprocal multiply
  always_comb begin
    rep_prod = 24'(item.report_number) * 24'(REP_RECIP);
    rep_quo  = rep_prod[23:16];
    rem      = item.report_number - 8'(16'(rep_quo) * 16'(NUM_REPORTS));
  end

  always_comb begin
    cls.error_code    = err;
    cls.reversed      = swap;
    cls.item_kind     = item.item_kind;
    cls.rep           = rem;
    cls.bit_add       = 16'(item.field_size) * 16'(item.field_count);
    cls.fix_log_low   = lmin2;
    cls.fix_log_high  = lmax2;
    cls.fix_phys_low  = phys_eq_or_inv ? lmin2 : item.physical_low;
    cls.fix_phys_high = phys_eq_or_inv ? lmax2 : item.physical_high;
    cls.usage_total   = item.usage_total;
    cls.string_total  = item.string_total;
  end

endmodule

`default_nettype wire

>>> hdl/hmil_queue.sv
// ----------------------------------------------------------------------------
// hmil_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module hmil_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  hmil_pkg::cls_item_t  push_item,
  output logic                 full,
  input  wire                  pop,
  output logic                 head_valid,
  output hmil_pkg::cls_item_t  head_item
);
  import hmil_pkg::*;

  localparam int DEPTH = 4;
  localparam int PW    = $clog2(DEPTH);

  cls_item_t     slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [PW:0]   count;

  assign full       = count == (PW+1)'(DEPTH);
  assign head_valid = count != '0;
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hdl/hmil_back.sv
// ----------------------------------------------------------------------------
// hmil_back
// Counter memory read-modify-write, list spans and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module hmil_back #(
  parameter int NUM_REPORTS = 256
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_write,
  input  wire                  cfg_data,
  input  wire                  q_valid,
  input  hmil_pkg::cls_item_t  q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output hmil_pkg::out_item_t  out_item
);
  import hmil_pkg::*;

  localparam int RW = (NUM_REPORTS > 1) ? $clog2(NUM_REPORTS) : 1;

  row_t             mem [NUM_REPORTS];
  logic [NUM_REPORTS-1:0] row_vld;

  logic             strict;
  logic             s1_valid;
  cls_item_t        s1_item;
  row_t             rd_row;
  logic             rd_vld;
  logic             fwd_hit;
  row_t             fwd_row;
  logic [15:0]      usage_start;
  logic [15:0]      string_start;

  logic             adv;
  logic             reject;
  logic             wr_en;
  row_t             cur_row;
  row_t             new_row;
  logic [CTR_W-1:0] cur_cnt;
  logic [RW-1:0]    s1_idx;
  logic [RW-1:0]    q_idx;

  assign s1_idx = s1_item.rep[RW-1:0];
  assign q_idx  = q_item.rep[RW-1:0];
  assign adv    = s1_valid && (!out_valid || !out_stall);
  assign q_pop  = q_valid && (!s1_valid || adv);
  assign reject = strict && (s1_item.error_code != ERR_NONE);
  assign wr_en  = adv && !reject && (s1_item.item_kind != KIND_OTHER);

  always_comb begin
    cur_row = fwd_hit ? fwd_row : (rd_vld ? rd_row : '0);
    new_row = cur_row;
    case (s1_item.item_kind)
      KIND_INPUT: begin
        cur_cnt = cur_row[CTR_INPUT];
        new_row[CTR_INPUT] = cur_cnt + CTR_W'(s1_item.bit_add);
      end
      KIND_OUTPUT: begin
        cur_cnt = cur_row[CTR_OUTPUT];
        new_row[CTR_OUTPUT] = cur_cnt + CTR_W'(s1_item.bit_add);
      end
      KIND_FEATURE: begin
        cur_cnt = cur_row[CTR_FEATURE];
        new_row[CTR_FEATURE] = cur_cnt + CTR_W'(s1_item.bit_add);
      end
      default: begin
        cur_cnt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[s1_idx] <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rd_row  <= mem[q_idx];
      s1_item <= q_item;
      fwd_row <= new_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strict       <= 1'b0;
      row_vld      <= '0;
      s1_valid     <= 1'b0;
      rd_vld       <= 1'b0;
      fwd_hit      <= 1'b0;
      usage_start  <= '0;
      string_start <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_write) begin
        strict <= cfg_data;
      end
      if (wr_en) begin
        row_vld[s1_idx] <= 1'b1;
      end
      if (q_pop) begin
        s1_valid <= 1'b1;
        rd_vld   <= row_vld[q_idx];
        fwd_hit  <= wr_en && (s1_idx == q_idx);
      end else if (adv) begin
        s1_valid <= 1'b0;
      end
      if (adv && !reject) begin
        usage_start  <= s1_item.usage_total;
        string_start <= s1_item.string_total;
      end
      if (adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.error_code          <= s1_item.error_code;
      out_item.reversed            <= s1_item.reversed;
      out_item.report_kind         <= reject ? KIND_OTHER : s1_item.item_kind;
      out_item.start_bit           <= reject ? '0 : cur_cnt;
      out_item.fixed_logical_low   <= s1_item.fix_log_low;
      out_item.fixed_logical_high  <= s1_item.fix_log_high;
      out_item.fixed_physical_low  <= s1_item.fix_phys_low;
      out_item.fixed_physical_high <= s1_item.fix_phys_high;
      out_item.first_usage         <= reject ? '0 : usage_start;
      out_item.usage_span          <= reject ? '0 : s1_item.usage_total - usage_start;
      out_item.first_string        <= reject ? '0 : string_start;
      out_item.string_span         <= reject ? '0 : s1_item.string_total - string_start;
    end
  end

endmodule

`default_nettype wire

>>> hdl/hid_main_item_layout.sv
// ----------------------------------------------------------------------------
// hid_main_item_layout
// Lays out HID main items within their reports and repairs their ranges.
// ----------------------------------------------------------------------------
// Takes one beat per cycle sustained while in_stall is low and returns one result
// beat per item, in order; each item passes through the queue, stage s1 and the
// output register. The rate is set by the per-report bit counter memory, which
// is read as an item enters s1 and written as it leaves, with the last
// write forwarded to a back-to-back item of the same report. Counters start
// at zero after reset through one valid bit per report, so no clearing pass is
// needed. strict_checking (cfg_data on cfg_write) must be written only while no
// beat is in flight; the block itself does not enforce this.
`default_nettype none

module hid_main_item_layout #(
  parameter int NUM_REPORTS = 256
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  hmil_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  wire                  out_stall,
  output hmil_pkg::out_item_t  out_item,
  input  wire                  cfg_write,
  input  wire                  cfg_data
);
  import hmil_pkg::*;

  cls_item_t cls;
  cls_item_t q_item;
  logic      q_full;
  logic      q_valid;
  logic      q_pop;

  assign in_stall = q_full;

  hmil_front #(.NUM_REPORTS(NUM_REPORTS)) u_front (
    .item (in_item),
    .cls  (cls)
  );

  hmil_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && !q_full),
    .push_item  (cls),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  hmil_back #(.NUM_REPORTS(NUM_REPORTS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> hdl/hmil_checker.sv
// ----------------------------------------------------------------------------
// hmil_checker
// Port-level checks on the HID main item layout block.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module hmil_checker (
  input wire                 clk,
  input wire                 rst,
  input wire                 out_valid,
  input wire                 out_stall,
  input hmil_pkg::out_item_t out_item
);
  import hmil_pkg::*;

  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_item), "stalled result beat changed")
  `ASSERT_SAME(a_log_order, clk, rst, out_valid, $signed(out_item.fixed_logical_low) <= $signed(out_item.fixed_logical_high), "logical range not ordered")
  `ASSERT_SAME(a_phys_order, clk, rst, out_valid, $signed(out_item.fixed_physical_low) <= $signed(out_item.fixed_physical_high), "physical range not ordered")
  `ASSERT_SAME(a_rev_err, clk, rst, out_valid && out_item.reversed, out_item.error_code != ERR_NONE, "swap without error")
  `ASSERT_SAME(a_other_start, clk, rst, out_valid && (out_item.report_kind == KIND_OTHER), out_item.start_bit == '0, "start bit without report kind")

endmodule

bind hid_main_item_layout hmil_checker u_hmil_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

`default_nettype wire

>>> verif/hmil_layout_checker.sv
// ----------------------------------------------------------------------------
// hmil_layout_checker
// Watches both channels of hid_main_item_layout and checks every result beat.
// ----------------------------------------------------------------------------
// Keeps its own copy of the strict flag, the per-report bit counters and the
// usage and string marks, lays out each accepted main item from them, and
// compares each result beat field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module hmil_layout_checker
  import hmil_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  input  logic      cfg_write,
  input  logic      cfg_data,
  output int        fail_count,
  output int        open_count,
  output int        results_seen,
  output int        rejected_count
);

  bit          strict_mode;
  bit [31:0]   bits_used [3][256];
  bit [15:0]   usage_mark;
  bit [15:0]   string_mark;
  out_item_t   layout_q[$];
  out_item_t   want;

  initial begin
    fail_count     = 0;
    open_count     = 0;
    results_seen   = 0;
    rejected_count = 0;
  end

  function automatic out_item_t lay_out_main_item(in_item_t it);
    out_item_t res;
    longint    lo;
    longint    hi;
    longint    plo;
    longint    phi;
    longint    top_v;
    longint    tmp;
    int        cap;
    int        ctr;
    bit [31:0] add;
    res   = '0;
    cap   = (it.field_size >= SIZE_CAP) ? SIZE_CAP : int'(it.field_size);
    top_v = (longint'(1) << cap) - 1;
    lo    = longint'($signed(it.logical_low));
    hi    = longint'($signed(it.logical_high));
    plo   = longint'($signed(it.physical_low));
    phi   = longint'($signed(it.physical_high));
    res.error_code = ERR_NONE;
    if (lo > top_v) begin
      res.error_code = ERR_LOG_MIN;
      lo = 0;
    end
    if (hi > top_v) begin
      if (res.error_code == ERR_NONE) res.error_code = ERR_LOG_MAX;
      hi = top_v;
    end
    if (lo > hi) begin
      if (res.error_code == ERR_NONE) res.error_code = ERR_LOG_INV;
      res.reversed = 1'b1;
      tmp = lo;
      lo  = hi;
      hi  = tmp;
    end
    if (res.error_code == ERR_NONE && it.half_range_marks[0]) res.error_code = ERR_USAGE;
    if (res.error_code == ERR_NONE && it.half_range_marks[1]) res.error_code = ERR_STRING;
    if (res.error_code == ERR_NONE && it.half_range_marks[2]) res.error_code = ERR_DESIG;
    if (plo >= phi) begin
      if (res.error_code == ERR_NONE && plo > phi) res.error_code = ERR_PHYS_INV;
      plo = lo;
      phi = hi;
    end
    res.fixed_logical_low   = lo[31:0];
    res.fixed_logical_high  = hi[31:0];
    res.fixed_physical_low  = plo[31:0];
    res.fixed_physical_high = phi[31:0];
    if (res.error_code != ERR_NONE && strict_mode) begin
      rejected_count++;
    end else begin
      res.first_usage  = usage_mark;
      res.usage_span   = it.usage_total - usage_mark;
      usage_mark       = it.usage_total;
      res.first_string = string_mark;
      res.string_span  = it.string_total - string_mark;
      string_mark      = it.string_total;
      ctr = -1;
      case (it.item_kind)
        KIND_INPUT:   ctr = CTR_INPUT;
        KIND_OUTPUT:  ctr = CTR_OUTPUT;
        KIND_FEATURE: ctr = CTR_FEATURE;
        default:      ctr = -1;
      endcase
      if (ctr >= 0) begin
        add = {24'd0, it.field_size} * {24'd0, it.field_count};
        res.report_kind = it.item_kind;
        res.start_bit   = bits_used[ctr][it.report_number];
        bits_used[ctr][it.report_number] = res.start_bit + add;
      end
    end
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want_v,
                             input logic [31:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s expected %h, got %h", $time, name, want_v, got_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      strict_mode = 1'b0;
      usage_mark  = '0;
      string_mark = '0;
      for (int k = 0; k < 3; k++) begin
        for (int r = 0; r < 256; r++) bits_used[k][r] = '0;
      end
      layout_q.delete();
    end else begin
      if (cfg_write) strict_mode = cfg_data;
      if (in_valid && !in_stall) layout_q.push_back(lay_out_main_item(in_item));
      if (out_valid && !out_stall) begin
        results_seen++;
        if (layout_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, out_item);
          fail_count++;
        end else begin
          want = layout_q.pop_front();
          check_field("error_code", 32'(want.error_code), 32'(out_item.error_code));
          check_field("reversed", 32'(want.reversed), 32'(out_item.reversed));
          check_field("report_kind", 32'(want.report_kind), 32'(out_item.report_kind));
          check_field("start_bit", want.start_bit, out_item.start_bit);
          check_field("fixed_logical_low", want.fixed_logical_low,
                      out_item.fixed_logical_low);
          check_field("fixed_logical_high", want.fixed_logical_high,
                      out_item.fixed_logical_high);
          check_field("fixed_physical_low", want.fixed_physical_low,
                      out_item.fixed_physical_low);
          check_field("fixed_physical_high", want.fixed_physical_high,
                      out_item.fixed_physical_high);
          check_field("first_usage", 32'(want.first_usage), 32'(out_item.first_usage));
          check_field("usage_span", 32'(want.usage_span), 32'(out_item.usage_span));
          check_field("first_string", 32'(want.first_string), 32'(out_item.first_string));
          check_field("string_span", 32'(want.string_span), 32'(out_item.string_span));
        end
      end
    end
    open_count = layout_q.size();
  end

endmodule

>>> verif/tb_hid_main_item_layout.sv
// ----------------------------------------------------------------------------
// tb_hid_main_item_layout
// Stimulus and verdict for the HID main item layout block.
// ----------------------------------------------------------------------------
// Drives directed main items (range repairs, every error code, field extremes,
// all kinds) under both strict settings, a back-to-back burst on one bit
// counter, then random phases with random sender gaps and receiver stalls.
// The checker beside the block predicts and compares every beat.
// ----------------------------------------------------------------------------
module tb_hid_main_item_layout;
  import hmil_pkg::*;

  localparam int SAME_REPORT_BURST = 60;
  localparam int PHASE_ITEMS       = 85;
  localparam int DRAIN_CYCLES      = 8;

  logic      clk       = 1'b0;
  logic      rst       = 1'b1;
  logic      in_valid  = 1'b0;
  in_item_t  in_item   = '0;
  logic      out_stall = 1'b0;
  logic      cfg_write = 1'b0;
  logic      cfg_data  = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  int        fail_count;
  int        open_count;
  int        results_seen;
  int        rejected_count;

  int        in_gap_max  = 0;
  int        out_gap_max = 0;
  int        items_sent  = 0;
  bit [15:0] usage_run   = '0;
  bit [15:0] string_run  = '0;

  always #5 clk = ~clk;

  hid_main_item_layout dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data)
  );

  hmil_layout_checker checker_i (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_item        (in_item),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_item       (out_item),
    .cfg_write      (cfg_write),
    .cfg_data       (cfg_data),
    .fail_count     (fail_count),
    .open_count     (open_count),
    .results_seen   (results_seen),
    .rejected_count (rejected_count)
  );

  function automatic in_item_t make_item(logic [1:0] kind, int size, int count, int rep,
                                         logic [31:0] ll, logic [31:0] lh,
                                         logic [31:0] pl, logic [31:0] ph,
                                         int marks, int ut, int st);
    in_item_t it;
    it.item_kind        = kind;
    it.field_size       = 8'(size);
    it.field_count      = 8'(count);
    it.report_number    = 8'(rep);
    it.logical_low      = ll;
    it.logical_high     = lh;
    it.physical_low     = pl;
    it.physical_high    = ph;
    it.half_range_marks = 3'(marks);
    it.usage_total      = 16'(ut);
    it.string_total     = 16'(st);
    return it;
  endfunction

  function automatic in_item_t random_main_item();
    in_item_t it;
    int       pick;
    int       cap;
    longint   top_v;
    longint   hi_v;
    longint   lo_v;
    it = '0;
    it.item_kind = ($urandom_range(0, 7) == 0) ? KIND_OTHER : 2'($urandom_range(1, 3));
    pick = $urandom_range(0, 19);
    if (pick < 13)       it.field_size = 8'($urandom_range(1, 16));
    else if (pick == 13) it.field_size = 8'd0;
    else if (pick == 14) it.field_size = 8'd31;
    else if (pick == 15) it.field_size = 8'd32;
    else if (pick == 16) it.field_size = 8'd255;
    else                 it.field_size = 8'($urandom);
    it.field_count = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 8));
    pick = $urandom_range(0, 9);
    if (pick < 6)       it.report_number = 8'($urandom_range(0, 3));
    else if (pick == 6) it.report_number = 8'd255;
    else                it.report_number = 8'($urandom);
    cap   = (it.field_size >= 31) ? 31 : int'(it.field_size);
    top_v = (longint'(1) << cap) - 1;
    if ($urandom_range(0, 4) == 0) begin
      it.logical_low  = $urandom;
      it.logical_high = $urandom;
    end else begin
      hi_v = longint'($urandom) % (top_v + 1);
      lo_v = hi_v - longint'($urandom_range(0, 1000));
      if ($urandom_range(0, 9) == 0) begin
        it.logical_low  = 32'(hi_v);
        it.logical_high = 32'(lo_v);
      end else begin
        it.logical_low  = 32'(lo_v);
        it.logical_high = 32'(hi_v);
      end
    end
    pick = $urandom_range(0, 9);
    it.physical_low = 32'($urandom_range(0, 2000)) - 32'd1000;
    if (pick < 7)       it.physical_high = it.physical_low + 32'($urandom_range(1, 1000));
    else if (pick == 7) it.physical_high = it.physical_low;
    else if (pick == 8) it.physical_high = it.physical_low - 32'($urandom_range(1, 1000));
    else begin
      it.physical_low  = $urandom;
      it.physical_high = $urandom;
    end
    it.half_range_marks = ($urandom_range(0, 6) == 0) ? 3'($urandom_range(1, 7)) : 3'd0;
    if ($urandom_range(0, 19) == 0) usage_run = 16'($urandom);
    else                            usage_run = usage_run + 16'($urandom_range(0, 4));
    if ($urandom_range(0, 19) == 0) string_run = 16'($urandom);
    else                            string_run = string_run + 16'($urandom_range(0, 2));
    it.usage_total  = usage_run;
    it.string_total = string_run;
    return it;
  endfunction

  // Returns right after the edge at which the beat is taken; valid stays up.
  task automatic send_main_item(input in_item_t it);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_strict(input bit on);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_data  <= on;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  // Result side: hold a random stall before each beat.
  initial begin
    int n;
    forever begin
      n = $urandom_range(0, out_gap_max);
      if (n > 0) begin
        @(negedge clk);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  initial begin
    #5000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    in_item_t it;
    bit       strict_plan [6];
    int       pick;
    strict_plan = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    in_gap_max  = 3;
    out_gap_max = 3;
    set_strict(1'b0);
    send_main_item(make_item(KIND_INPUT, 8, 4, 0, 0, 255, 0, 1000, 0, 3, 1));
    send_main_item(make_item(KIND_INPUT, 8, 4, 0, -128, 127, -10, 10, 0, 5, 2));
    send_main_item(make_item(KIND_OUTPUT, 0, 255, 255, 0, 0, 5, 5, 0, 5, 2));
    send_main_item(make_item(KIND_FEATURE, 255, 255, 255, 32'h8000_0000, 32'h7fff_ffff,
                             32'h8000_0000, 32'h7fff_ffff, 0, 9, 4));
    send_main_item(make_item(KIND_OTHER, 16, 2, 0, 0, 100, 0, 10, 0, 12, 6));
    send_main_item(make_item(KIND_INPUT, 1, 1, 1, 2, 1, 0, 1, 0, 12, 6));
    send_main_item(make_item(KIND_INPUT, 4, 3, 1, 0, 100, 0, 1, 0, 13, 6));
    send_main_item(make_item(KIND_INPUT, 4, 3, 1, 10, 3, 0, 1, 0, 14, 7));
    send_main_item(make_item(KIND_OUTPUT, 2, 5, 2, 5, -3, 0, 1, 0, 14, 7));
    send_main_item(make_item(KIND_OUTPUT, 8, 1, 2, 0, 10, 0, 1, 1, 15, 7));
    send_main_item(make_item(KIND_FEATURE, 8, 1, 2, 0, 10, 0, 1, 2, 15, 8));
    send_main_item(make_item(KIND_FEATURE, 8, 1, 2, 0, 10, 0, 1, 4, 16, 8));
    send_main_item(make_item(KIND_INPUT, 8, 1, 3, 0, 10, 0, 1, 7, 16, 9));
    send_main_item(make_item(KIND_INPUT, 8, 2, 3, 0, 10, 10, -10, 0, 17, 9));
    send_main_item(make_item(KIND_INPUT, 31, 1, 3, -1, 32'h7fff_ffff, 0, 1, 0, 18, 9));
    send_main_item(make_item(KIND_OUTPUT, 32, 8, 3, 0, 32'h7fff_ffff, 0, 1, 0, 2, 1));
    send_main_item(make_item(KIND_OUTPUT, 12, 3, 128, -5, 5, 3, 4, 0, 65535, 0));
    send_main_item(make_item(KIND_FEATURE, 255, 255, 255, 32'hffff_ffff, 32'hffff_ffff,
                             32'hffff_ffff, 32'hffff_ffff, 7, 65535, 65535));
    send_main_item(make_item(KIND_OTHER, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));

    set_strict(1'b1);
    send_main_item(make_item(KIND_INPUT, 4, 2, 0, 0, 100, 0, 1, 0, 20, 3));
    send_main_item(make_item(KIND_INPUT, 4, 2, 0, 0, 10, 0, 1, 2, 21, 4));
    send_main_item(make_item(KIND_OUTPUT, 4, 2, 0, 0, 10, 7, 3, 0, 22, 5));
    send_main_item(make_item(KIND_INPUT, 4, 2, 0, 0, 10, 0, 1, 0, 23, 6));

    // Back-to-back run on one counter.
    set_strict(1'b0);
    in_gap_max  = 0;
    out_gap_max = 0;
    for (int i = 0; i < SAME_REPORT_BURST; i++) begin
      it = random_main_item();
      it.item_kind     = KIND_INPUT;
      it.report_number = 8'd7;
      it.field_size    = 8'd255;
      it.field_count   = 8'd255;
      send_main_item(it);
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_strict(strict_plan[ph]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 25 == 0) begin
          pick = $urandom_range(0, 2);
          in_gap_max  = (pick == 0) ? 0 : (pick == 1) ? 3 : 18;
          pick = $urandom_range(0, 2);
          out_gap_max = (pick == 0) ? 0 : (pick == 1) ? 3 : 18;
          if (ph == 0) begin
            in_gap_max  = 0;
            out_gap_max = 0;
          end
        end
        if (ph == 2 && i == 50) wait_idle();
        send_main_item(random_main_item());
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;
    while (open_count != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d main items, %0d of them a back-to-back run on one report counter,",
             items_sent, SAME_REPORT_BURST);
    $display("under strict off and on; %0d result beats checked, %0d items rejected.",
             results_seen, rejected_count);
    if (fail_count == 0 && open_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
